// ===== rtl/grc_pkg.sv =====
// ----------------------------------------------------------------------------
// Grid raycast column renderer package
// Shared types, register indexes, glyph codes and the sine table builder.
// ----------------------------------------------------------------------------
package grc_pkg;

    localparam int SINE_DEPTH = 1025;
    localparam int SINE_AW    = 11;
    localparam int SINE_W     = 15;
    localparam int DIV_W      = 22;
    localparam int DVS_W      = 10;
    localparam int DIV_CNT_W  = 5;
    localparam int STEP_W     = 8;
    localparam int MUL_W      = 18;
    localparam int PROD_W     = 36;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_W      = 64;
    localparam int IN_TDATA_W = 56;
    localparam int OUT_TDATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_WALL_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WALL_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WALL_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WALL_D = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FOV    = 3'd6;

    localparam logic [3:0] GLYPH_SPACE  = 4'd0;
    localparam logic [3:0] GLYPH_FULL   = 4'd1;
    localparam logic [3:0] GLYPH_DARK   = 4'd2;
    localparam logic [3:0] GLYPH_MEDIUM = 4'd3;
    localparam logic [3:0] GLYPH_LIGHT  = 4'd4;
    localparam logic [3:0] GLYPH_HASH   = 4'd5;
    localparam logic [3:0] GLYPH_X      = 4'd6;
    localparam logic [3:0] GLYPH_DOT    = 4'd7;
    localparam logic [3:0] GLYPH_DASH   = 4'd8;

    localparam logic [16:0] ALIGN_CROSS_K = 17'd99997;

    typedef enum logic [4:0] {
        S_IDLE, S_COLMUL, S_COLDIV, S_COLWAIT,
        S_SINE_X, S_SINE_Y, S_SINE_W, S_MARCH,
        S_DIST_X, S_DIST_Y, S_DIST_SUM,
        S_AL_EXVX, S_AL_EYVY, S_AL_EXVY, S_AL_EYVX, S_AL_ABS,
        S_AL_CRLO, S_AL_CRHI, S_AL_CMP,
        S_CEILMUL, S_CEILDIV, S_CEILWAIT, S_EMIT
    } grc_state_t;

    typedef logic [SINE_W-1:0] sine_table_t [0:SINE_DEPTH-1];

    function automatic logic [SINE_W-1:0] quarter_sine(input int r);
        logic [63:0] x, x2, t, s;
        x = 64'(r) * 64'd1647099;
        x2 = (x * x) >> 30;
        t = x;
        s = x;
        for (int k = 1; k <= 6; k++) begin
            t = ((t * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if ((k & 1) != 0) s = s - t;
            else s = s + t;
        end
        return SINE_W'((s + 64'd32768) >> 16);
    endfunction

    function automatic sine_table_t build_sine_table();
        sine_table_t tab;
        for (int i = 0; i < SINE_DEPTH; i++) tab[i] = quarter_sine(i);
        return tab;
    endfunction

endpackage

// ===== rtl/grc_sine_rom.sv =====
// ----------------------------------------------------------------------------
// Quarter-wave sine table
// Registered-read table of the first quarter of a sine wave in unsigned Q1.14.
// ----------------------------------------------------------------------------
module grc_sine_rom (
    input  logic                       aclk,
    input  logic [grc_pkg::SINE_AW-1:0] addr,
    output logic [grc_pkg::SINE_W-1:0]  data_reg
);
    import grc_pkg::*;

    localparam sine_table_t SINE_TABLE = build_sine_table();

    always_ff @(posedge aclk) begin
        data_reg <= SINE_TABLE[addr];
    end

endmodule

// ===== rtl/grc_mul.sv =====
// ----------------------------------------------------------------------------
// Shared multiplier
// One registered signed multiplier that the sequencer feeds every cycle.
// ----------------------------------------------------------------------------
module grc_mul (
    input  logic                               aclk,
    input  logic signed [grc_pkg::MUL_W-1:0]   a,
    input  logic signed [grc_pkg::MUL_W-1:0]   b,
    output logic signed [grc_pkg::PROD_W-1:0]  prod_reg
);
    import grc_pkg::*;

    always_ff @(posedge aclk) begin
        prod_reg <= a * b;
    end

endmodule

// ===== rtl/grc_div.sv =====
// ----------------------------------------------------------------------------
// Serial divider
// Unsigned restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module grc_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [grc_pkg::DIV_W-1:0]     dividend,
    input  logic [grc_pkg::DVS_W-1:0]     divisor,
    output logic                          busy_reg,
    output logic                          done_reg,
    output logic [grc_pkg::DIV_W-1:0]     quo_reg
);
    import grc_pkg::*;

    logic [DVS_W-1:0]     rem_reg;
    logic [DVS_W-1:0]     dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DVS_W:0]       trial;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
    end

endmodule

// ===== rtl/grid_raycast_column_renderer.sv =====
// ----------------------------------------------------------------------------
// Grid raycast column renderer
// Marches one ray per column over a wall bitmap and emits a glyph per row.
// ----------------------------------------------------------------------------
// A column word is taken only in the idle state. Forming the ray angle takes
// a serial divide and two sine table reads, the march takes one step per cycle
// up to 10*MAX_DEPTH steps, the corner test on a hit puts all its products
// through one shared multiplier, the ceiling divide runs next, and then one
// row is emitted per cycle when the output is taken at once.
// The block does not accept a new word until the last row has been loaded.
module grid_raycast_column_renderer #(
    parameter int MAP_SIZE  = 16,
    parameter int MAX_DEPTH = 16,
    parameter int MAX_ROWS  = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // player_x[15:0], player_y[31:16], view_angle[43:32], column[53:44]
    input  logic [grc_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // row[5:0], glyph[9:6], wall_steps[17:10]
    output logic [grc_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                m_tlast,
    input  logic                                cfg_we,
    input  logic [grc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [grc_pkg::CFG_W-1:0]           cfg_data
);
    import grc_pkg::*;

    localparam int LIMIT = 10 * MAX_DEPTH;

    grc_state_t state_reg, state_next;

    logic [63:0] wall_reg [0:3];
    logic [9:0]  width_reg;
    logic [6:0]  height_reg;
    logic [11:0] fov_reg;

    logic [15:0] px_reg, py_reg;
    logic [11:0] va_reg, ray_reg;
    logic [9:0]  col_reg;
    logic signed [15:0] ex_reg, ey_reg;
    logic signed [23:0] qx_reg, qy_reg;
    logic [STEP_W-1:0]  k_reg, steps_reg;
    logic [3:0]  cx_reg, cy_reg;
    logic [1:0]  corner_reg, a_reg, b_reg;
    logic        b_valid_reg, phase_reg, boundary_reg;
    logic [33:0] sq_reg, da_reg, db_reg;
    logic signed [35:0] p_reg, dp_reg;
    logic [31:0] cr_reg;
    logic [35:0] lo_reg;
    logic [6:0]  h_reg, y_reg;
    logic signed [11:0] ceil_reg;
    logic        neg_reg;

    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic m_tvalid_reg, m_tlast_reg;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic [SINE_AW-1:0] rom_addr;
    logic [SINE_W-1:0]  rom_data;
    logic        div_start, div_busy, div_done;
    logic [DIV_W-1:0] div_dividend, div_quo;
    logic [DVS_W-1:0] div_divisor;

    grc_sine_rom u_rom (.aclk(aclk), .addr(rom_addr), .data_reg(rom_data));
    grc_mul u_mul (.aclk(aclk), .a(mul_a), .b(mul_b), .prod_reg(prod));
    grc_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(div_dividend),
        .divisor(div_divisor), .busy_reg(div_busy), .done_reg(div_done), .quo_reg(div_quo)
    );

    // Sine lookup helpers.
    function automatic logic [SINE_AW-1:0] sine_addr(input logic [11:0] ang);
        return ang[10] ? SINE_AW'(11'd1024 - {1'b0, ang[9:0]}) : {1'b0, ang[9:0]};
    endfunction

    function automatic logic signed [15:0] sine_val(input logic [11:0] ang,
                                                    input logic [SINE_W-1:0] m);
        return ang[11] ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

    // March point decode.
    logic [7:0]  qxs, qys;
    logic [15:0] cxm, cym;
    logic [5:0]  cxw, cyw;
    logic        out_map, is_wall;
    logic [63:0] wrow;

    assign qxs = qx_reg[22:15];
    assign qys = qy_reg[22:15];
    assign cxm = qxs * 8'd205;
    assign cym = qys * 8'd205;
    assign cxw = cxm[15:10];
    assign cyw = cym[15:10];
    assign out_map = qx_reg[23] || qy_reg[23] ||
                     (32'(cxw) >= MAP_SIZE) || (32'(cyw) >= MAP_SIZE);
    assign wrow = wall_reg[cyw[3:2]];
    assign is_wall = wrow[{cyw[1:0], cxw[3:0]}];

    // Corner vectors.
    logic [1:0] vsel;
    logic signed [MUL_W-1:0] vx, vy;
    logic [4:0] cxp, cyp;

    always_comb begin
        unique case (state_reg)
            S_DIST_X, S_DIST_Y, S_DIST_SUM: vsel = corner_reg;
            default:                         vsel = phase_reg ? b_reg : a_reg;
        endcase
    end

    assign cxp = {1'b0, cx_reg} + {4'b0, vsel[1]};
    assign cyp = {1'b0, cy_reg} + {4'b0, vsel[0]};
    assign vx = $signed({1'b0, cxp, 12'b0}) - $signed({2'b0, px_reg});
    assign vy = $signed({1'b0, cyp, 12'b0}) - $signed({2'b0, py_reg});

    logic signed [MUL_W-1:0] ex18, ey18;
    assign ex18 = {{2{ex_reg[15]}}, ex_reg};
    assign ey18 = {{2{ey_reg[15]}}, ey_reg};

    logic [33:0] d2;
    assign d2 = 34'(prod) + sq_reg;

    logic signed [35:0] crd;
    assign crd = p_reg - prod;

    logic [49:0] cr_scaled, dp_scaled, dp_wide;
    logic        align_hit;
    assign cr_scaled = {prod[32:0], 17'b0} + {14'b0, lo_reg};
    assign dp_wide   = {{14{dp_reg[35]}}, dp_reg};
    assign dp_scaled = (dp_wide << 10) - (dp_wide << 4) - (dp_wide << 3);
    assign align_hit = (dp_reg > 0) && (cr_scaled < dp_scaled);

    logic [6:0] h_sat;
    assign h_sat = (32'(height_reg) > MAX_ROWS) ? 7'(MAX_ROWS) : height_reg;

    logic signed [8:0] steps_m20;
    assign steps_m20 = $signed({1'b0, steps_reg}) - 9'sd20;

    logic [9:0] w_eff;
    assign w_eff = (width_reg == '0) ? 10'd1 : width_reg;

    logic [DIV_W-1:0] ceil_mag;
    assign ceil_mag = prod[PROD_W-1] ? DIV_W'(-prod) : DIV_W'(prod);

    logic last_corner;
    assign last_corner = corner_reg == 2'd3;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (s_tvalid) state_next = S_COLMUL;
            S_COLMUL:   state_next = S_COLDIV;
            S_COLDIV:   state_next = S_COLWAIT;
            S_COLWAIT:  if (div_done) state_next = S_SINE_X;
            S_SINE_X:   state_next = S_SINE_Y;
            S_SINE_Y:   state_next = S_SINE_W;
            S_SINE_W:   state_next = S_MARCH;
            S_MARCH: begin
                if (out_map) state_next = S_CEILMUL;
                else if (is_wall) state_next = S_DIST_X;
                else if (32'(k_reg) >= LIMIT) state_next = S_CEILMUL;
            end
            S_DIST_X:   state_next = S_DIST_Y;
            S_DIST_Y:   state_next = S_DIST_SUM;
            S_DIST_SUM: state_next = last_corner ? S_AL_EXVX : S_DIST_X;
            S_AL_EXVX:  state_next = S_AL_EYVY;
            S_AL_EYVY:  state_next = S_AL_EXVY;
            S_AL_EXVY:  state_next = S_AL_EYVX;
            S_AL_EYVX:  state_next = S_AL_ABS;
            S_AL_ABS:   state_next = S_AL_CRLO;
            S_AL_CRLO:  state_next = S_AL_CRHI;
            S_AL_CRHI:  state_next = S_AL_CMP;
            S_AL_CMP:   state_next = phase_reg ? S_CEILMUL : S_AL_EXVX;
            S_CEILMUL:  state_next = (h_sat == '0) ? S_IDLE : S_CEILDIV;
            S_CEILDIV:  state_next = S_CEILWAIT;
            S_CEILWAIT: if (div_done) state_next = S_EMIT;
            S_EMIT: begin
                if ((!m_tvalid_reg || m_tready) && (y_reg == h_reg - 7'd1))
                    state_next = S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // Datapath controls.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        rom_addr = sine_addr(ray_reg);
        div_start = 1'b0;
        div_dividend = DIV_W'(prod);
        div_divisor = w_eff;
        unique case (state_reg)
            S_COLMUL: begin
                mul_a = {8'b0, col_reg};
                mul_b = {6'b0, fov_reg};
            end
            S_COLDIV:  div_start = 1'b1;
            S_SINE_Y:  rom_addr = sine_addr(ray_reg + 12'd1024);
            S_DIST_X: begin
                mul_a = vx;
                mul_b = vx;
            end
            S_DIST_Y: begin
                mul_a = vy;
                mul_b = vy;
            end
            S_AL_EXVX: begin
                mul_a = ex18;
                mul_b = vx;
            end
            S_AL_EYVY: begin
                mul_a = ey18;
                mul_b = vy;
            end
            S_AL_EXVY: begin
                mul_a = ex18;
                mul_b = vy;
            end
            S_AL_EYVX: begin
                mul_a = ey18;
                mul_b = vx;
            end
            S_AL_CRLO: begin
                mul_a = {1'b0, cr_reg[16:0]};
                mul_b = {1'b0, ALIGN_CROSS_K};
            end
            S_AL_CRHI: begin
                mul_a = {3'b0, cr_reg[31:17]};
                mul_b = {1'b0, ALIGN_CROSS_K};
            end
            S_CEILMUL: begin
                mul_a = {11'b0, h_sat};
                mul_b = {{9{steps_m20[8]}}, steps_m20};
            end
            S_CEILDIV: begin
                div_start = 1'b1;
                div_dividend = ceil_mag;
                div_divisor = {1'b0, steps_reg, 1'b0};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else state_reg <= state_next;
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wall_reg[0] <= '0;
            wall_reg[1] <= '0;
            wall_reg[2] <= '0;
            wall_reg[3] <= '0;
            width_reg   <= 10'd120;
            height_reg  <= 7'd40;
            fov_reg     <= 12'd512;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_WALL_A: wall_reg[0] <= cfg_data;
                CFG_WALL_B: wall_reg[1] <= cfg_data;
                CFG_WALL_C: wall_reg[2] <= cfg_data;
                CFG_WALL_D: wall_reg[3] <= cfg_data;
                CFG_WIDTH:  width_reg   <= cfg_data[9:0];
                CFG_HEIGHT: height_reg  <= cfg_data[6:0];
                CFG_FOV:    fov_reg     <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // Working registers.
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                px_reg <= s_tdata[15:0];
                py_reg <= s_tdata[31:16];
                va_reg <= s_tdata[43:32];
                col_reg <= s_tdata[53:44];
                boundary_reg <= 1'b0;
                steps_reg <= STEP_W'(LIMIT);
            end
            S_COLWAIT: ray_reg <= va_reg - {1'b0, fov_reg[11:1]} + div_quo[11:0];
            S_SINE_Y:  ex_reg <= sine_val(ray_reg, rom_data);
            S_SINE_W: begin
                ey_reg <= sine_val(ray_reg + 12'd1024, rom_data);
                qx_reg <= $signed({8'b0, px_reg} * 24'd40) + 24'(ex_reg);
                qy_reg <= $signed({8'b0, py_reg} * 24'd40)
                          + 24'(sine_val(ray_reg + 12'd1024, rom_data));
                k_reg  <= STEP_W'(1);
            end
            S_MARCH: begin
                qx_reg <= qx_reg + 24'(ex_reg);
                qy_reg <= qy_reg + 24'(ey_reg);
                k_reg  <= k_reg + 1'b1;
                cx_reg <= cxw[3:0];
                cy_reg <= cyw[3:0];
                corner_reg <= '0;
                b_valid_reg <= 1'b0;
                phase_reg <= 1'b0;
                if (!out_map && is_wall) steps_reg <= k_reg;
            end
            S_DIST_Y: sq_reg <= 34'(prod);
            S_DIST_SUM: begin
                corner_reg <= corner_reg + 1'b1;
                if (corner_reg == '0 || d2 < da_reg) begin
                    a_reg <= corner_reg;
                    da_reg <= d2;
                    if (corner_reg != '0) begin
                        b_reg <= a_reg;
                        db_reg <= da_reg;
                        b_valid_reg <= 1'b1;
                    end
                end else if (!b_valid_reg || d2 < db_reg) begin
                    b_reg <= corner_reg;
                    db_reg <= d2;
                    b_valid_reg <= 1'b1;
                end
            end
            S_AL_EYVY: p_reg <= prod;
            S_AL_EXVY: dp_reg <= p_reg + prod;
            S_AL_EYVX: p_reg <= prod;
            S_AL_ABS:  cr_reg <= crd[35] ? 32'(-crd) : 32'(crd);
            S_AL_CRHI: lo_reg <= prod;
            S_AL_CMP: begin
                boundary_reg <= boundary_reg | align_hit;
                phase_reg <= 1'b1;
            end
            S_CEILMUL: begin
                h_reg <= h_sat;
                y_reg <= '0;
            end
            S_CEILDIV: neg_reg <= prod[PROD_W-1];
            S_CEILWAIT: begin
                if (div_done)
                    ceil_reg <= neg_reg ? -$signed({2'b0, div_quo[9:0]})
                                        : $signed({2'b0, div_quo[9:0]});
            end
            S_EMIT: if (!m_tvalid_reg || m_tready) y_reg <= y_reg + 1'b1;
            default: ;
        endcase
    end

    // Glyph selection.
    logic signed [11:0] y_s, floor_s;
    logic [3:0]  shade, glyph;
    logic [6:0]  r_rows;
    logic [9:0]  r8, r4, h3;
    logic [11:0] r20, h9;

    assign y_s = $signed({5'b0, y_reg});
    assign floor_s = $signed({5'b0, h_reg}) - ceil_reg;
    assign r_rows = h_reg - y_reg;
    assign r8 = {r_rows, 3'b0};
    assign r4 = {1'b0, r_rows, 2'b0};
    assign h3 = 10'(h_reg) * 10'd3;
    assign r20 = 12'(r_rows) * 12'd20;
    assign h9 = 12'(h_reg) * 12'd9;

    always_comb begin
        if (boundary_reg) shade = GLYPH_SPACE;
        else if (32'(steps_reg) * 4 <= LIMIT) shade = GLYPH_FULL;
        else if (32'(steps_reg) * 3 <= LIMIT) shade = GLYPH_DARK;
        else if (32'(steps_reg) * 2 <= LIMIT) shade = GLYPH_MEDIUM;
        else shade = GLYPH_LIGHT;

        if (y_s <= ceil_reg) glyph = GLYPH_SPACE;
        else if (y_s <= floor_s) glyph = shade;
        else if (r8 < 10'(h_reg)) glyph = GLYPH_HASH;
        else if (r4 < 10'(h_reg)) glyph = GLYPH_X;
        else if (r8 < h3) glyph = GLYPH_DOT;
        else if (r20 < h9) glyph = GLYPH_DASH;
        else glyph = GLYPH_SPACE;
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == S_EMIT && (!m_tvalid_reg || m_tready)) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_EMIT && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= {6'b0, steps_reg, glyph, y_reg[5:0]};
            m_tlast_reg <= y_reg == h_reg - 7'd1;
        end
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_march_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_MARCH |-> (k_reg != '0) && (32'(k_reg) <= LIMIT))
        else $error("march step count out of range");

    a_emit_rows: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_EMIT |-> (h_reg != '0) && (y_reg < h_reg))
        else $error("row counter beyond screen height");

    a_idle_div: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> !div_busy)
        else $error("divider busy while idle");

    a_steps_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[17:10] != '0) && (32'(m_tdata[17:10]) <= LIMIT))
        else $error("wall distance out of range");

endmodule

// ===== tb/sv/tb_grid_raycast_column_renderer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the grid raycast column renderer
// Drives player position, heading and column words through a queue-fed
// driver, predicts every glyph row with an independent ray march, and checks
// each output word against the oldest predicted row.
// ----------------------------------------------------------------------------
module tb_grid_raycast_column_renderer;
    import grc_pkg::*;

    typedef struct {
        logic [5:0] row;
        logic [3:0] glyph;
        logic [7:0] steps;
        logic       last;
    } glyph_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data = '0;

    logic [IN_TDATA_W-1:0]  column_q[$];
    glyph_row_t             glyph_row_q[$];
    longint                 sin_tab[0:1024];
    logic [63:0]            map_bits[4];
    int unsigned            width_reg, height_reg, fov_reg;
    bit                     steady = 1'b0;
    int                     mismatches = 0;
    int                     columns_sent = 0;
    int                     rows_checked = 0;
    int                     hits = 0;
    int                     blank_walls = 0;

    grid_raycast_column_renderer uut (.*);

    always #5 aclk = ~aclk;

    function automatic longint quarter_wave(int unsigned r);
        logic [63:0] x, x2, t, s;
        x = 64'(r & 2047) * 64'd1647099;
        x2 = (x * x) >> 30;
        t = x;
        s = x;
        for (int k = 1; k <= 6; k++) begin
            t = ((t * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) s = s - t;
            else s = s + t;
        end
        return longint'((s + 64'd32768) >> 16);
    endfunction

    function automatic longint sine_of(int unsigned a);
        int unsigned q, r;
        longint m;
        q = (a >> 10) & 3;
        r = a & 1023;
        m = (q & 1) ? sin_tab[1024 - r] : sin_tab[r];
        return (q & 2) ? -m : m;
    endfunction

    function automatic bit corner_aligned(longint ex, longint ey, longint vx, longint vy);
        longint dp, cr;
        dp = ex * vx + ey * vy;
        cr = ex * vy - ey * vx;
        if (dp <= 0) return 1'b0;
        if (cr < 0) cr = -cr;
        return cr * 99997 < dp * 1000;
    endfunction

    task automatic predict_column(input logic [IN_TDATA_W-1:0] word);
        longint px, py, ex, ey, qx, qy, cx, cy, steps, h, ceil_row, floor_row, r;
        longint vx[4], vy[4], d2[4];
        int unsigned va, col, w, ray;
        int a, b;
        bit blank;
        logic [3:0] shade, g;
        glyph_row_t e;
        px = longint'(word[15:0]);
        py = longint'(word[31:16]);
        va = word[43:32];
        col = word[53:44];
        w = (width_reg != 0) ? width_reg : 1;
        ray = (va - (fov_reg >> 1) + (col * fov_reg) / w) & 4095;
        ex = sine_of(ray);
        ey = sine_of((ray + 1024) & 4095);
        steps = 160;
        blank = 1'b0;
        for (longint k = 1; k <= 160; k++) begin
            qx = px * 40 + ex * k;
            qy = py * 40 + ey * k;
            if (qx < 0 || qy < 0) break;
            cx = qx / 163840;
            cy = qy / 163840;
            if (cx >= 16 || cy >= 16) break;
            if (map_bits[cy >> 2][(cy % 4) * 16 + cx]) begin
                a = 0;
                b = -1;
                for (int i = 0; i < 4; i++) begin
                    vx[i] = (cx + (i >> 1)) * 4096 - px;
                    vy[i] = (cy + (i & 1)) * 4096 - py;
                    d2[i] = vx[i] * vx[i] + vy[i] * vy[i];
                    if (d2[i] < d2[a]) a = i;
                end
                for (int i = 0; i < 4; i++)
                    if (i != a && (b < 0 || d2[i] < d2[b])) b = i;
                blank = corner_aligned(ex, ey, vx[a], vy[a]) ||
                        corner_aligned(ex, ey, vx[b], vy[b]);
                steps = k;
                hits++;
                if (blank) blank_walls++;
                break;
            end
        end
        h = (height_reg > 64) ? 64 : height_reg;
        ceil_row = (h * steps - 20 * h) / (2 * steps);
        floor_row = h - ceil_row;
        if (4 * steps <= 160) shade = GLYPH_FULL;
        else if (3 * steps <= 160) shade = GLYPH_DARK;
        else if (2 * steps <= 160) shade = GLYPH_MEDIUM;
        else shade = GLYPH_LIGHT;
        if (blank) shade = GLYPH_SPACE;
        for (longint y = 0; y < h; y++) begin
            r = h - y;
            if (y <= ceil_row) g = GLYPH_SPACE;
            else if (y <= floor_row) g = shade;
            else if (8 * r < h) g = GLYPH_HASH;
            else if (4 * r < h) g = GLYPH_X;
            else if (8 * r < 3 * h) g = GLYPH_DOT;
            else if (20 * r < 9 * h) g = GLYPH_DASH;
            else g = GLYPH_SPACE;
            e.row = 6'(y);
            e.glyph = g;
            e.steps = 8'(steps);
            e.last = (y == h - 1);
            glyph_row_q = {glyph_row_q, e};
        end
        columns_sent++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) predict_column(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (column_q.size() > 0 && (steady || $urandom_range(99) >= 19)) begin
                    s_tdata <= column_q.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        glyph_row_t e;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                rows_checked++;
                if (glyph_row_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected word: row %0d glyph %0d steps %0d last %0d",
                                 m_tdata[5:0], m_tdata[9:6], m_tdata[17:10], m_tlast);
                end else begin
                    e = glyph_row_q.pop_front();
                    if (m_tdata[5:0] !== e.row || m_tdata[9:6] !== e.glyph ||
                        m_tdata[17:10] !== e.steps || m_tlast !== e.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"Mismatch: expected row %0d glyph %0d steps %0d last %0d,",
                                      " got row %0d glyph %0d steps %0d last %0d"},
                                     e.row, e.glyph, e.steps, e.last, m_tdata[5:0],
                                     m_tdata[9:6], m_tdata[17:10], m_tlast);
                    end
                end
            end
            m_tready <= steady || ($urandom_range(99) >= 19);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_WALL_A, CFG_WALL_B, CFG_WALL_C, CFG_WALL_D: map_bits[idx] = val;
            CFG_WIDTH: width_reg = val & 1023;
            CFG_HEIGHT: height_reg = val & 127;
            CFG_FOV: fov_reg = val & 4095;
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_map(input bit border, input int density);
        logic [63:0] rows[4];
        int x, y;
        rows = '{default: '0};
        for (y = 0; y < 16; y++)
            for (x = 0; x < 16; x++)
                if ((border && (x == 0 || y == 0 || x == 15 || y == 15)) ||
                    $urandom_range(99) < density)
                    rows[y >> 2][(y % 4) * 16 + x] = 1'b1;
        write_reg(CFG_WALL_A, rows[0]);
        write_reg(CFG_WALL_B, rows[1]);
        write_reg(CFG_WALL_C, rows[2]);
        write_reg(CFG_WALL_D, rows[3]);
    endtask

    task automatic send_column(input int px, input int py, input int va, input int col);
        logic [IN_TDATA_W-1:0] word;
        word = {2'b00, 10'(col), 12'(va), 16'(py), 16'(px)};
        column_q = {column_q, word};
    endtask

    task automatic drain();
        while (column_q.size() > 0 || s_tvalid || glyph_row_q.size() > 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic send_random_columns(input int count);
        int cx, cy;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 80) begin
                cx = $urandom_range(1, 14);
                cy = $urandom_range(1, 14);
                send_column(cx * 4096 + $urandom_range(4095), cy * 4096 + $urandom_range(4095),
                            $urandom_range(4095),
                            $urandom_range((width_reg > 0 ? width_reg : 1) - 1));
            end else begin
                send_column($urandom_range(65535), $urandom_range(65535),
                            $urandom_range(4095), $urandom_range(1023));
            end
        end
    endtask

    initial begin
        int widths[6] = '{1, 1023, 0, 120, 64, 7};
        int heights[7] = '{2, 64, 127, 0, 24, 9, 40};
        int fovs[6] = '{1, 2048, 4095, 0, 512, 1365};
        for (int i = 0; i <= 1024; i++) sin_tab[i] = quarter_wave(i);
        map_bits = '{default: '0};
        width_reg = 120;
        height_reg = 40;
        fov_reg = 512;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty map: every ray leaves the map or runs out of steps.
        send_column(0, 0, 0, 0);
        send_column(65535, 65535, 4095, 1023);
        send_column(8 * 4096, 8 * 4096, 1024, 60);
        send_column(8 * 4096, 8 * 4096, 2048, 119);
        send_column(8 * 4096, 8 * 4096, 3072, 120);
        send_column(2048, 2048, 2560, 30);
        drain();

        // Bordered map with a lone wall on the diagonal for the blank edge case.
        load_map(1'b1, 0);
        map_bits[2][2 * 16 + 10] = 1'b1;
        write_reg(CFG_WALL_C, map_bits[2]);
        send_column(8 * 4096 + 2048, 8 * 4096 + 2048, 512, 60);
        send_column(8 * 4096 + 2048, 8 * 4096 + 2048, 512, 61);
        send_column(4096, 4096, 2048, 60);
        send_column(4096, 4096, 3072, 60);
        send_column(14 * 4096, 8 * 4096, 1024, 0);
        send_column(8 * 4096, 8 * 4096, 0, 119);
        send_column(15 * 4096, 15 * 4096, 512, 60);
        send_column(4096, 4096, 0, 60);
        send_column(8 * 4096, 14 * 4096 + 4095, 0, 60);
        drain();

        write_reg(CFG_HEIGHT, 127);
        write_reg(CFG_WIDTH, 1023);
        write_reg(CFG_FOV, 2048);
        send_column(8 * 4096, 8 * 4096, 100, 0);
        send_column(8 * 4096, 8 * 4096, 100, 1023);
        send_column(1 * 4096, 14 * 4096, 3000, 511);
        drain();
        write_reg(CFG_HEIGHT, 0);
        send_column(8 * 4096, 8 * 4096, 100, 5);
        drain();

        for (int p = 0; p < 9; p++) begin
            load_map(1'b1, $urandom_range(5, 30));
            write_reg(CFG_WIDTH, (p < 6) ? widths[p] : $urandom_range(1, 1023));
            write_reg(CFG_HEIGHT, (p < 7) ? heights[p] : $urandom_range(2, 64));
            write_reg(CFG_FOV, (p < 6) ? fovs[p] : $urandom_range(1, 2048));
            steady = (p == 4);
            send_random_columns(50);
            drain();
        end
        steady = 1'b0;

        $display("Rendered %0d columns and checked %0d glyph rows;", columns_sent, rows_checked);
        $display("%0d rays hit a wall and %0d of those were blank edges.", hits, blank_walls);
        if (mismatches == 0 && glyph_row_q.size() == 0) begin
            $display("tb_grid_raycast_column_renderer: PASS");
        end else begin
            $display("%0d mismatches, %0d rows still expected.", mismatches, glyph_row_q.size());
            $display("tb_grid_raycast_column_renderer: FAIL");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Timeout with %0d rows still expected.", glyph_row_q.size());
        $display("tb_grid_raycast_column_renderer: FAIL");
        $finish;
    end

endmodule
